@@ design/bfm_pkg.sv @@
`default_nettype none

package bfm_pkg;

  localparam int unsigned MaxWidth = 1024;
  localparam int unsigned ColW     = $clog2(MaxWidth);
  localparam int unsigned PixW     = 8;
  localparam int unsigned WidthW   = 11;
  localparam int unsigned HeightW  = 12;
  localparam int unsigned InRowW   = HeightW + 1;
  localparam int unsigned CfgDataW = 12;
  localparam int unsigned SumW     = 12;

  // floor(s / 9) == (s * Recip9) >> RecipShift for every 9-pixel sum
  localparam int unsigned RecipShift = 16;
  localparam logic [12:0] Recip9     = 13'd7282;

  localparam logic [WidthW-1:0]  WidthMin  = WidthW'(3);
  localparam logic [WidthW-1:0]  WidthMax  = WidthW'(MaxWidth);
  localparam logic [HeightW-1:0] HeightMin = HeightW'(3);
  localparam logic [WidthW-1:0]  WidthRst  = WidthW'(640);
  localparam logic [HeightW-1:0] HeightRst = HeightW'(480);

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PixW-1:0] pix_t;

  // one line-store entry: pixel of the row two back, pixel of the row one back
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_t;

  typedef struct packed {
    logic          valid;
    logic [ColW-1:0] col;
    pix_t          bot;
    logic          emit;
    logic          interior;
    logic          eof;
  } p1_t;

  typedef struct packed {
    logic            valid;
    logic [SumW-1:0] sum;
    pix_t            pass;
    logic            interior;
    logic            eof;
  } p2_t;

endpackage

`default_nettype wire

@@ design/box_filter_3x3_mean.sv @@
`default_nettype none

// 3x3 mean filter over an 8-bit grey pixel stream in raster order.
// Slave stream: one pixel per word in tdata; tuser marks a flush word.
// After each frame of image_height x image_width pixels, send
// image_width + 1 flush words; results trail the input by a row plus a pixel.
// Master stream: filtered pixel in tdata, tlast on the last pixel of a frame.
// Interior pixels get floor(sum of the 3x3 neighborhood / 9); border pixels
// pass through unchanged. Flush words sent during the pixel phase are dropped.
// Configuration: cfg_we_i writes cfg_data_i to the register at cfg_idx_i
// (0 = image width, 1 = image height); write only while the stream is idle.
// Throughput: one word per cycle unless the master side stalls. Pipeline:
// accept with line-store read into p1_q and line_rd_q, window sum into p2_q,
// divide by nine into the output register that drives the master side.
// The single read port of the line store, read once per advancing cycle,
// sets the rate of one word per cycle.
// A stall on the master side freezes the whole pipeline; s_axis_tready
// drops only while a result waits in the output register.
// Reset clears counters, window and valid bits and sets 640 x 480.
// The line store is not cleared; it is written before each read that counts.
module box_filter_3x3_mean (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_idx_i,
  input  wire logic [bfm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,   // [7:0] pixel
  input  wire logic                          s_axis_tuser,   // [0] drain
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [7:0]                         m_axis_tdata,   // [7:0] value
  output logic                               m_axis_tlast
);

  // configuration
  logic [bfm_pkg::WidthW-1:0]  width_q;
  logic [bfm_pkg::HeightW-1:0] height_q;
  logic [bfm_pkg::WidthW-1:0]  w_eff;
  logic [bfm_pkg::HeightW-1:0] h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bfm_pkg::WidthRst;
      height_q <= bfm_pkg::HeightRst;
    end else if (cfg_we_i) begin
      case (bfm_pkg::cfg_reg_e'(cfg_idx_i))
        bfm_pkg::REG_WIDTH:  width_q  <= cfg_data_i[bfm_pkg::WidthW-1:0];
        bfm_pkg::REG_HEIGHT: height_q <= cfg_data_i[bfm_pkg::HeightW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q < bfm_pkg::WidthMin)      w_eff = bfm_pkg::WidthMin;
    else if (width_q > bfm_pkg::WidthMax) w_eff = bfm_pkg::WidthMax;
    else                                  w_eff = width_q;
    h_eff = (height_q < bfm_pkg::HeightMin) ? bfm_pkg::HeightMin : height_q;
  end

  // pipeline enable: everything moves unless a result is stuck at the output
  logic adv;
  logic s_hs;
  logic take;
  logic flushing;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign s_hs          = s_axis_tvalid && adv;

  // position counters
  logic [bfm_pkg::ColW-1:0]    in_col_q, in_col_d;
  logic [bfm_pkg::InRowW-1:0]  in_row_q, in_row_d;
  logic [bfm_pkg::ColW-1:0]    out_col_q, out_col_d;
  logic [bfm_pkg::HeightW-1:0] out_row_q, out_row_d;

  logic emit, interior, eof;
  logic [bfm_pkg::WidthW-1:0]  in_col_nx, out_col_nx;
  logic [bfm_pkg::HeightW:0]   out_row_p1, out_row_p2;

  assign flushing   = in_row_q >= bfm_pkg::InRowW'(h_eff);
  assign take       = s_hs && !(s_axis_tuser && !flushing);
  assign in_col_nx  = bfm_pkg::WidthW'(in_col_q) + 1'b1;
  assign out_col_nx = bfm_pkg::WidthW'(out_col_q) + 1'b1;
  assign out_row_p1 = (bfm_pkg::HeightW+1)'(out_row_q) + 1'b1;
  assign out_row_p2 = (bfm_pkg::HeightW+1)'(out_row_q) + 2'd2;

  always_comb begin
    emit     = (in_row_q >= bfm_pkg::InRowW'(2))
            || (in_row_q == bfm_pkg::InRowW'(1) && in_col_q != '0);
    interior = out_row_q != '0 && out_row_p2 <= (bfm_pkg::HeightW+1)'(h_eff)
            && out_col_q != '0 && (out_col_nx + 1'b1) <= w_eff;
    eof      = emit && out_row_p1 >= (bfm_pkg::HeightW+1)'(h_eff)
            && out_col_nx >= w_eff;

    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (take) begin
      if (eof) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end else begin
        if (in_col_nx >= w_eff) begin
          in_col_d = '0;
          in_row_d = in_row_q + 1'b1;
        end else begin
          in_col_d = in_col_nx[bfm_pkg::ColW-1:0];
        end
        if (emit) begin
          if (out_col_nx >= w_eff) begin
            out_col_d = '0;
            out_row_d = out_row_q + 1'b1;
          end else begin
            out_col_d = out_col_nx[bfm_pkg::ColW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // line store: both previous rows in one entry
  bfm_pkg::line_t line_mem [bfm_pkg::MaxWidth];
  bfm_pkg::line_t line_rd_q;

  bfm_pkg::p1_t p1_q, p1_d;
  bfm_pkg::p2_t p2_q, p2_d;
  bfm_pkg::pix_t win_q [6];
  bfm_pkg::pix_t win_d [6];

  always_comb begin
    p1_d.valid    = take;
    p1_d.col      = in_col_q;
    p1_d.bot      = flushing ? '0 : s_axis_tdata;
    p1_d.emit     = emit;
    p1_d.interior = interior;
    p1_d.eof      = eof;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      line_rd_q <= line_mem[in_col_q];
      if (p1_q.valid) begin
        line_mem[p1_q.col] <= '{upper: line_rd_q.middle, middle: p1_q.bot};
      end
    end
  end

  // window shift and neighborhood sum
  always_comb begin
    win_d[0] = win_q[3];
    win_d[1] = win_q[4];
    win_d[2] = win_q[5];
    win_d[3] = line_rd_q.upper;
    win_d[4] = line_rd_q.middle;
    win_d[5] = p1_q.bot;

    p2_d.valid    = p1_q.valid && p1_q.emit;
    p2_d.sum      = bfm_pkg::SumW'(line_rd_q.upper) + bfm_pkg::SumW'(line_rd_q.middle)
                  + bfm_pkg::SumW'(p1_q.bot)
                  + bfm_pkg::SumW'(win_q[0]) + bfm_pkg::SumW'(win_q[1])
                  + bfm_pkg::SumW'(win_q[2]) + bfm_pkg::SumW'(win_q[3])
                  + bfm_pkg::SumW'(win_q[4]) + bfm_pkg::SumW'(win_q[5]);
    p2_d.pass     = win_q[4];
    p2_d.interior = p1_q.interior;
    p2_d.eof      = p1_q.eof;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q.valid <= 1'b0;
      p2_q.valid <= 1'b0;
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (adv) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      if (p1_q.valid) begin
        for (int i = 0; i < 6; i++) win_q[i] <= win_d[i];
      end
    end
  end

  // divide by nine through the reciprocal
  logic [24:0]   prod;
  bfm_pkg::pix_t value_d;

  assign prod    = 25'(p2_q.sum) * 25'(bfm_pkg::Recip9);
  assign value_d = p2_q.interior
                 ? prod[bfm_pkg::RecipShift +: bfm_pkg::PixW] : p2_q.pass;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= p2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= value_d;
      m_axis_tlast <= p2_q.eof;
    end
  end

endmodule

`default_nettype wire

@@ design/bfm_checker.sv @@
`default_nettype none

module bfm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tready,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [7:0]                    m_axis_tdata,
  input wire logic                          m_axis_tlast
);

  // a waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // input side stays open while the output register is empty
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty output");

  a_ready_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |-> s_axis_tready)
    else $error("input blocked while result taken");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while pipeline frozen");

endmodule

bind box_filter_3x3_mean bfm_checker u_bfm_checker (.*);

`default_nettype wire
